// ----- rtl/srctok_pkg.sv -----
// Shared types, kind codes and helper functions for the source tokenizer.
package srctok_pkg;

	localparam int OFFSET_BITS = 16;
	localparam int OUT_W = 16;

	typedef logic [OFFSET_BITS-1:0] pos_t;
	typedef logic [OFFSET_BITS:0] pos_ext_t;
	typedef logic [4:0] kind_t;

	localparam kind_t KIND_NUM = 5'd0;
	localparam kind_t KIND_ID = 5'd1;
	localparam kind_t KIND_KW_BASE = 5'd2;
	localparam kind_t KIND_STRING = 5'd7;
	localparam kind_t KIND_NEWLINE = 5'd8;
	localparam kind_t KIND_PUNCT_BASE = 5'd9;
	localparam kind_t KIND_PUNCT_LAST = 5'd24;
	localparam kind_t KIND_END = 5'd25;

	typedef enum logic [2:0] {
		MODE_IDLE,
		MODE_NUM,
		MODE_ID,
		MODE_STR,
		MODE_DONE
	} mode_t;

	typedef struct packed {
		kind_t kind;
		logic [OUT_W-1:0] start;
		logic [OUT_W-1:0] len;
		logic unterm;
	} tok_t;

	// All tokens caused by one source byte, slot 0 first.
	typedef struct packed {
		tok_t [2:0] tok;
		logic [1:0] cnt;
	} grp_t;

	localparam int Q_DEPTH = 4;
	localparam int Q_AW = $clog2(Q_DEPTH);

	function automatic pos_t sat_inc(pos_t v);
		return (v == '1) ? v : v + pos_t'(1);
	endfunction

	function automatic logic [OUT_W-1:0] clamp_out(pos_ext_t v);
		logic [63:0] w;
		w = 64'(v);
		return (w > 64'hFFFF) ? 16'hFFFF : w[OUT_W-1:0];
	endfunction

	// Builds a token from a start offset and an end offset one past the last byte.
	function automatic tok_t make_tok(kind_t kind, pos_ext_t start, pos_ext_t stop,
			logic unterm);
		tok_t t;
		pos_ext_t len;
		len = (stop > start) ? stop - start : '0;
		t.kind = kind;
		t.start = clamp_out(start);
		t.len = clamp_out(len);
		t.unterm = unterm;
		return t;
	endfunction

endpackage

// ----- rtl/srctok_lexer.sv -----
// Lexer state and the combinational step that turns one byte into up to three tokens.
module srctok_lexer (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                accept,
	input  logic [7:0]          ch,
	input  logic                last,
	output srctok_pkg::grp_t    grp,
	output logic                push
);

	localparam logic [7:0] PUNCT [16] = '{8'h3D, 8'h3B, 8'h2C, 8'h2E, 8'h27, 8'h5F,
		8'h28, 8'h29, 8'h3C, 8'h3E, 8'h2F, 8'h5C, 8'h2B, 8'h2D, 8'h2A, 8'h3F};

	// Keyword spellings, zero padded: int, string, sout, if, while.
	localparam logic [7:0] KW_TEXT [5][8] = '{
		'{8'h69, 8'h6E, 8'h74, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
		'{8'h73, 8'h74, 8'h72, 8'h69, 8'h6E, 8'h67, 8'h00, 8'h00},
		'{8'h73, 8'h6F, 8'h75, 8'h74, 8'h00, 8'h00, 8'h00, 8'h00},
		'{8'h69, 8'h66, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
		'{8'h77, 8'h68, 8'h69, 8'h6C, 8'h65, 8'h00, 8'h00, 8'h00}};
	localparam logic [2:0] KW_LEN [5] = '{3'd3, 3'd6, 3'd4, 3'd2, 3'd5};

	srctok_pkg::mode_t mode_q, mode_d;
	srctok_pkg::pos_t  pos_q, pos_d;
	srctok_pkg::pos_t  tstart_q, tstart_d;
	logic [4:0]        cand_q, cand_d;
	logic [2:0]        idcnt_q, idcnt_d;
	logic [2:0]        n;

	function automatic logic is_digit(logic [7:0] c);
		return (c >= 8'h30) && (c <= 8'h39);
	endfunction

	function automatic logic is_alpha(logic [7:0] c);
		return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
	endfunction

	function automatic logic is_blank(logic [7:0] c);
		return (c == 8'h20) || (c == 8'h09) || (c == 8'h0B) || (c == 8'h0C) ||
			(c == 8'h0D);
	endfunction

	// Drops keywords that no longer match after one more letter.
	function automatic logic [4:0] kw_filter(logic [4:0] cand, logic [2:0] cnt,
			logic [7:0] c);
		logic [4:0] r;
		r = cand;
		for (int k = 0; k < 5; k++) begin
			if ((cnt >= KW_LEN[k]) || (KW_TEXT[k][cnt] != c))
				r[k] = 1'b0;
		end
		return r;
	endfunction

	function automatic srctok_pkg::kind_t id_kind(logic [4:0] cand, logic [2:0] cnt);
		srctok_pkg::kind_t r;
		r = srctok_pkg::KIND_ID;
		for (int k = 4; k >= 0; k--) begin
			if (cand[k] && (cnt == KW_LEN[k]))
				r = srctok_pkg::KIND_KW_BASE + srctok_pkg::kind_t'(k);
		end
		return r;
	endfunction

	always_comb begin
		srctok_pkg::pos_t     pos;
		srctok_pkg::pos_t     endp;
		srctok_pkg::pos_ext_t pos_x;
		srctok_pkg::pos_ext_t endp_x;
		srctok_pkg::kind_t    pk;
		logic                 pk_hit;

		pos = pos_q;
		endp = srctok_pkg::sat_inc(pos_q);
		pos_x = {1'b0, pos_q};
		endp_x = {1'b0, endp};
		mode_d = mode_q;
		tstart_d = tstart_q;
		cand_d = cand_q;
		idcnt_d = idcnt_q;
		grp = '0;
		n = '0;

		pk = srctok_pkg::KIND_END;
		pk_hit = 1'b0;
		for (int k = 0; k < 16; k++) begin
			if (PUNCT[k] == ch) begin
				pk_hit = 1'b1;
				pk = srctok_pkg::KIND_PUNCT_BASE + srctok_pkg::kind_t'(k);
			end
		end

		// A pending number or identifier is closed by a byte that cannot extend it.
		if ((mode_q == srctok_pkg::MODE_NUM) && !is_digit(ch)) begin
			grp.tok[n[1:0]] = srctok_pkg::make_tok(srctok_pkg::KIND_NUM,
				{1'b0, tstart_q}, pos_x, 1'b0);
			n = n + 3'd1;
			mode_d = srctok_pkg::MODE_IDLE;
		end else if ((mode_q == srctok_pkg::MODE_ID) && !is_alpha(ch)) begin
			grp.tok[n[1:0]] = srctok_pkg::make_tok(id_kind(cand_q, idcnt_q),
				{1'b0, tstart_q}, pos_x, 1'b0);
			n = n + 3'd1;
			mode_d = srctok_pkg::MODE_IDLE;
		end

		unique case (mode_d)
			srctok_pkg::MODE_NUM: begin
			end
			srctok_pkg::MODE_ID: begin
				cand_d = kw_filter(cand_d, idcnt_d, ch);
				if (idcnt_d != 3'd7)
					idcnt_d = idcnt_d + 3'd1;
			end
			srctok_pkg::MODE_STR: begin
				if (ch == 8'h22) begin
					grp.tok[n[1:0]] = srctok_pkg::make_tok(srctok_pkg::KIND_STRING,
						{1'b0, tstart_d}, pos_x, 1'b0);
					n = n + 3'd1;
					mode_d = srctok_pkg::MODE_IDLE;
				end else if (ch == 8'h00) begin
					grp.tok[n[1:0]] = srctok_pkg::make_tok(srctok_pkg::KIND_STRING,
						{1'b0, tstart_d}, pos_x, 1'b1);
					n = n + 3'd1;
					grp.tok[n[1:0]] = srctok_pkg::make_tok(srctok_pkg::KIND_END,
						pos_x, pos_x, 1'b0);
					n = n + 3'd1;
					mode_d = srctok_pkg::MODE_DONE;
				end
			end
			srctok_pkg::MODE_IDLE: begin
				if (is_digit(ch)) begin
					tstart_d = pos;
					mode_d = srctok_pkg::MODE_NUM;
				end else if (is_alpha(ch)) begin
					tstart_d = pos;
					cand_d = kw_filter(5'b11111, 3'd0, ch);
					idcnt_d = 3'd1;
					mode_d = srctok_pkg::MODE_ID;
				end else if (ch == 8'h22) begin
					tstart_d = endp;
					mode_d = srctok_pkg::MODE_STR;
				end else if (ch == 8'h0A) begin
					grp.tok[n[1:0]] = srctok_pkg::make_tok(srctok_pkg::KIND_NEWLINE,
						pos_x, pos_x + srctok_pkg::pos_ext_t'(1), 1'b0);
					n = n + 3'd1;
				end else if (!is_blank(ch)) begin
					if (pk_hit) begin
						grp.tok[n[1:0]] = srctok_pkg::make_tok(pk, pos_x,
							pos_x + srctok_pkg::pos_ext_t'(1), 1'b0);
					end else begin
						grp.tok[n[1:0]] = srctok_pkg::make_tok(srctok_pkg::KIND_END,
							pos_x, pos_x, 1'b0);
						mode_d = srctok_pkg::MODE_DONE;
					end
					n = n + 3'd1;
				end
			end
			srctok_pkg::MODE_DONE: begin
			end
			default: begin
			end
		endcase

		if (last) begin
			if (mode_d == srctok_pkg::MODE_NUM) begin
				grp.tok[n[1:0]] = srctok_pkg::make_tok(srctok_pkg::KIND_NUM,
					{1'b0, tstart_d}, endp_x, 1'b0);
				n = n + 3'd1;
			end else if (mode_d == srctok_pkg::MODE_ID) begin
				grp.tok[n[1:0]] = srctok_pkg::make_tok(id_kind(cand_d, idcnt_d),
					{1'b0, tstart_d}, endp_x, 1'b0);
				n = n + 3'd1;
			end else if (mode_d == srctok_pkg::MODE_STR) begin
				grp.tok[n[1:0]] = srctok_pkg::make_tok(srctok_pkg::KIND_STRING,
					{1'b0, tstart_d}, endp_x, 1'b1);
				n = n + 3'd1;
			end
			if (mode_d != srctok_pkg::MODE_DONE) begin
				grp.tok[n[1:0]] = srctok_pkg::make_tok(srctok_pkg::KIND_END,
					endp_x, endp_x, 1'b0);
				n = n + 3'd1;
			end
			mode_d = srctok_pkg::MODE_IDLE;
			pos_d = '0;
			tstart_d = '0;
			cand_d = 5'b11111;
			idcnt_d = 3'd0;
		end else begin
			pos_d = endp;
		end

		grp.cnt = n[1:0];
		push = accept && (n != 3'd0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= srctok_pkg::MODE_IDLE;
			pos_q <= '0;
			tstart_q <= '0;
			cand_q <= 5'b11111;
			idcnt_q <= 3'd0;
		end else if (accept) begin
			mode_q <= mode_d;
			pos_q <= pos_d;
			tstart_q <= tstart_d;
			cand_q <= cand_d;
			idcnt_q <= idcnt_d;
		end
	end

endmodule

// ----- rtl/srctok_outq.sv -----
// Queue of token groups that hands out one token per output beat.
module srctok_outq (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      push,
	input  srctok_pkg::grp_t          grp,
	output logic                      full,
	output logic                      tok_valid,
	input  logic                      tok_stall,
	output srctok_pkg::tok_t          tok,
	output logic                      last_slot
);

	srctok_pkg::grp_t               q_q [srctok_pkg::Q_DEPTH];
	logic [srctok_pkg::Q_AW-1:0]    wr_ptr_q;
	logic [srctok_pkg::Q_AW-1:0]    rd_ptr_q;
	logic [srctok_pkg::Q_AW:0]      count_q;
	logic [1:0]                     slot_q;
	srctok_pkg::grp_t               head;
	logic                           pop_beat;
	logic                           pop_grp;

	assign head = q_q[rd_ptr_q];
	assign tok = head.tok[slot_q];
	assign tok_valid = (count_q != '0);
	assign full = (count_q == (srctok_pkg::Q_AW + 1)'(srctok_pkg::Q_DEPTH));
	assign last_slot = (slot_q == (head.cnt - 2'd1));
	assign pop_beat = tok_valid && !tok_stall;
	assign pop_grp = pop_beat && last_slot;

	always_ff @(posedge clk) begin
		if (push)
			q_q[wr_ptr_q] <= grp;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
			slot_q <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop_grp)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			if (pop_grp)
				slot_q <= '0;
			else if (pop_beat)
				slot_q <= slot_q + 2'd1;
			if (push && !pop_grp)
				count_q <= count_q + 1'b1;
			else if (!push && pop_grp)
				count_q <= count_q - 1'b1;
		end
	end

endmodule

// ----- rtl/source_tokenizer.sv -----
// Top level of the streaming source tokenizer: byte input, token output.
//
//  Channel | Handshake            | Beat contents
//  --------+----------------------+-------------------------------------------------
//  source  | src_valid, src_stall | ch, last
//  token   | tok_valid, tok_stall | kind, start_res, length, unterminated, end_of_run
//
// One source byte is taken per cycle while src_stall is low; its tokens are queued and
// leave on the token channel in order, one token per cycle while tok_stall is low.
// A byte causes zero to three tokens; the sustained rate is one byte per cycle while
// bytes cause at most one token on average and tok_stall stays low, set by the output side.
// Tokens wait in a four-group queue; src_stall rises only while that queue is full.
// Reset clears the lexer to idle with offset zero and empties the queue.
module source_tokenizer (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        src_valid,
	output logic        src_stall,
	input  logic [7:0]  ch,
	input  logic        last,
	output logic        tok_valid,
	input  logic        tok_stall,
	output logic [4:0]  kind,
	output logic [15:0] start_res,
	output logic [15:0] length,
	output logic        unterminated,
	output logic        end_of_run
);

	logic             accept;
	logic             push;
	logic             full;
	srctok_pkg::grp_t grp;
	srctok_pkg::tok_t tok;

	// A byte is taken whenever the queue has a free group entry, so the source side keeps
	// moving while a finished token still waits on the token channel.
	assign src_stall = full;
	assign accept = src_valid && !full;

	// The lexer holds mode, offset, token start and the keyword match state, and
	// combinationally works out every token a byte causes together with the next state.
	srctok_lexer u_lexer (
		.clk    (clk),
		.arst_n (arst_n),
		.accept (accept),
		.ch     (ch),
		.last   (last),
		.grp    (grp),
		.push   (push)
	);

	// The queue stores each byte's tokens as one group and walks through its slots; the
	// final slot of a group carries the end-of-run mark.
	srctok_outq u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.grp       (grp),
		.full      (full),
		.tok_valid (tok_valid),
		.tok_stall (tok_stall),
		.tok       (tok),
		.last_slot (end_of_run)
	);

	assign kind = tok.kind;
	assign start_res = tok.start;
	assign length = tok.len;
	assign unterminated = tok.unterm;

endmodule

// ----- rtl/srctok_checker.sv -----
// Port-level checks for the source tokenizer and their binding to the top level.
module srctok_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        src_valid,
	input  logic        src_stall,
	input  logic [7:0]  ch,
	input  logic        last,
	input  logic        tok_valid,
	input  logic        tok_stall,
	input  logic [4:0]  kind,
	input  logic [15:0] start_res,
	input  logic [15:0] length,
	input  logic        unterminated,
	input  logic        end_of_run
);

	// A stalled token holds its valid and its payload.
	a_tok_hold: assert property (@(posedge clk) disable iff (!arst_n)
		tok_valid && tok_stall |=> tok_valid && $stable(kind) && $stable(start_res) &&
			$stable(length) && $stable(unterminated) && $stable(end_of_run))
		else $error("token changed while stalled");

	// The end token is always the final token of its byte and covers no text.
	a_end_token: assert property (@(posedge clk) disable iff (!arst_n)
		tok_valid && (kind == srctok_pkg::KIND_END) |-> end_of_run && (length == 16'd0))
		else $error("end token not last in run or with nonzero length");

	// Only strings carry the unterminated flag.
	a_unterm_string: assert property (@(posedge clk) disable iff (!arst_n)
		tok_valid && unterminated |-> (kind == srctok_pkg::KIND_STRING))
		else $error("unterminated flag on a non-string token");

	// Newline and punctuators are exactly one byte long.
	a_single_char: assert property (@(posedge clk) disable iff (!arst_n)
		tok_valid && (kind >= srctok_pkg::KIND_NEWLINE) &&
			(kind <= srctok_pkg::KIND_PUNCT_LAST) |-> (length == 16'd1))
		else $error("single-character token with wrong length");

endmodule

bind source_tokenizer srctok_checker u_srctok_checker (.*);
